@@ sv/gb5_pkg.sv @@
// Shared types and constants for the 5x5 Gaussian blur core.
`default_nettype none
package gb5_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int OUT_COL_W    = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int DIM_W        = 13;

    localparam int LINES        = 4;
    localparam int TAPS         = 5;
    localparam int LINE_WORD_W  = LINES * PIX_W;
    localparam int ROWSUM_W     = 14;
    localparam int SUM_W        = 16;
    localparam int PROD_W       = 2 * SUM_W;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 5;
    localparam int WIDTH_RST     = 1024;
    localparam int HEIGHT_RST    = 1024;

    // floor(x / 159) == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2^16
    localparam logic [SUM_W-1:0] DIV_RECIP = 16'd52759;
    localparam int               DIV_SHIFT = 23;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [TAPS-1:0][TAPS-1:0][3:0] KERNEL = {
        {4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        {4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        {4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        {4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        {4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    typedef logic [TAPS-1:0][PIX_W-1:0]    column_t;
    typedef logic [TAPS-1:0][ROWSUM_W-1:0] row_sums_t;

    typedef struct packed {
        logic                 last;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
    } meta_t;

endpackage
`default_nettype wire

@@ sv/gaussian_blur_5x5_core.sv @@
// Top level of the 5x5 Gaussian blur core: position counters, pipeline control, ports.
//
// Gray pixels enter in raster order at one pixel per clock while m_tready does not stall the
// output, and each interior pixel (two or more pixels from every edge) yields one result: the
// 2-4-5-4-2 / 4-9-12-9-4 / 5-12-15-12-5 weighted 5x5 sum divided by 159 and truncated, with
// the centre's row, column and an end-of-frame mark on tlast. Border pixels yield nothing. The
// pipeline is read stage, window, row sums, total, and the reciprocal multiply into the output
// register. The line store is one MAX_WIDTH x 32-bit memory, one read and one write per clock,
// and needs no clearing pass after reset. A configuration write to the width or height
// register restarts the frame at row 0, column 0; issue it only while no transaction is in
// flight. Widths (low 11 bits of cfg_data) outside 5..MAX_WIDTH and heights outside 5..4096
// are clamped.
`default_nettype none
module gaussian_blur_5x5_core #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: pixel[7:0]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [gb5_pkg::PIX_W-1:0]       s_tdata,
    // m_tdata: blurred[7:0], out_row[19:8], out_col[29:20], zero[31:30]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [31:0]                     m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gb5_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gb5_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RST_W  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [CW-1:0]    w_last_reg;
    logic [ROW_W-1:0] h_last_reg;
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;

    logic             cfg_write;
    logic [DIM_W-1:0] width_in;
    logic [DIM_W-1:0] height_in;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    logic s_accept;
    logic col_wrap;
    logic row_wrap;

    logic  p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, out_v_reg;
    logic  p1_rdy, p2_rdy, p3_rdy, p4_rdy, out_rdy;
    logic  p1_emit_reg;
    logic  [PIX_W-1:0] p1_px_reg;
    logic  [CW-1:0]    p1_col_reg;
    meta_t p1_meta_reg, p2_meta_reg, p3_meta_reg, p4_meta_reg, out_meta_reg;
    meta_t meta_next;
    logic  [CW-1:0] col_minus2;

    logic [LINE_WORD_W-1:0] line_rd;
    column_t                col_in;
    row_sums_t              row_sums;
    logic [PIX_W-1:0]       blurred;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign width_in  = DIM_W'(cfg_data[WIDTH_REG_W-1:0]);
    assign height_in = DIM_W'(cfg_data[HEIGHT_REG_W-1:0]);

    always_comb begin
        if (width_in < DIM_W'(MIN_DIM)) begin
            width_eff = DIM_W'(MIN_DIM);
        end else if (width_in > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = width_in;
        end
        if (height_in < DIM_W'(MIN_DIM)) begin
            height_eff = DIM_W'(MIN_DIM);
        end else if (height_in > DIM_W'(MAX_HEIGHT)) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_in;
        end
    end

    // ready chain, output back to input
    assign out_rdy  = !out_v_reg || m_tready;
    assign p4_rdy   = !p4_v_reg || out_rdy;
    assign p3_rdy   = !p3_v_reg || p4_rdy;
    assign p2_rdy   = !p2_v_reg || p3_rdy;
    assign p1_rdy   = !p1_v_reg || p2_rdy;
    assign s_tready = p1_rdy;
    assign s_accept = s_tvalid && s_tready;

    assign col_wrap = (col_count_reg == w_last_reg);
    assign row_wrap = (row_count_reg == h_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg    <= CW'(RST_W - 1);
            h_last_reg    <= ROW_W'(HEIGHT_RST - 1);
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (cfg_write) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                w_last_reg    <= CW'(width_eff - DIM_W'(1));
                col_count_reg <= '0;
                row_count_reg <= '0;
            end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                h_last_reg    <= ROW_W'(height_eff - DIM_W'(1));
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
        end else if (s_accept) begin
            if (col_wrap) begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // valid flags; only interior pixels go past the window stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (p1_rdy) begin
                p1_v_reg <= s_tvalid;
            end
            if (p2_rdy) begin
                p2_v_reg <= p1_v_reg && p1_emit_reg;
            end
            if (p3_rdy) begin
                p3_v_reg <= p2_v_reg;
            end
            if (p4_rdy) begin
                p4_v_reg <= p3_v_reg;
            end
            if (out_rdy) begin
                out_v_reg <= p4_v_reg;
            end
        end
    end

    assign col_minus2 = col_count_reg - CW'(2);
    assign meta_next  = {row_wrap && col_wrap, ROW_W'(row_count_reg - ROW_W'(2)),
                         OUT_COL_W'(col_minus2)};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_px_reg   <= s_tdata;
            p1_col_reg  <= col_count_reg;
            p1_emit_reg <= (row_count_reg >= ROW_W'(4)) && (col_count_reg >= CW'(4));
            p1_meta_reg <= meta_next;
        end
        if (p1_v_reg && p2_rdy) begin
            p2_meta_reg <= p1_meta_reg;
        end
        if (p2_v_reg && p3_rdy) begin
            p3_meta_reg <= p2_meta_reg;
        end
        if (p3_v_reg && p4_rdy) begin
            p4_meta_reg <= p3_meta_reg;
        end
        if (p4_v_reg && out_rdy) begin
            out_meta_reg <= p4_meta_reg;
        end
    end

    gb5_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_count_reg),
        .rd_data (line_rd),
        .wr_en   (p1_v_reg && p2_rdy),
        .wr_addr (p1_col_reg),
        .wr_data ({p1_px_reg, line_rd[LINE_WORD_W-1:PIX_W]})
    );

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            col_in[i] = line_rd[i*PIX_W +: PIX_W];
        end
        col_in[LINES] = p1_px_reg;
    end

    gb5_window u_window (
        .aclk     (aclk),
        .shift_en (p1_v_reg && p2_rdy),
        .col_in   (col_in),
        .sum_en   (p2_v_reg && p3_rdy),
        .row_sums (row_sums)
    );

    gb5_divide u_divide (
        .aclk     (aclk),
        .total_en (p3_v_reg && p4_rdy),
        .row_sums (row_sums),
        .out_en   (p4_v_reg && out_rdy),
        .blurred  (blurred)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_meta_reg.col, out_meta_reg.row, blurred};
    assign m_tlast  = out_meta_reg.last;

`ifndef ASSERT_OFF
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_count_reg <= w_last_reg)
        else $error("column counter past row end");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg <= h_last_reg)
        else $error("row counter past frame end");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> p1_v_reg)
        else $error("accepted transaction lost at read stage");

    a_last_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_meta_reg.col == OUT_COL_W'(w_last_reg - CW'(2)))
        else $error("end of frame marked off the last interior column");
`endif

endmodule
`default_nettype wire

@@ sv/gb5_line_buf.sv @@
// Line store: four previous rows packed per column, registered read.
`default_nettype none
module gb5_line_buf #(
    parameter int DEPTH = gb5_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(gb5_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                            aclk,
    input  wire logic                            rd_en,
    input  wire logic [AW-1:0]                   rd_addr,
    output logic      [gb5_pkg::LINE_WORD_W-1:0] rd_data,
    input  wire logic                            wr_en,
    input  wire logic [AW-1:0]                   wr_addr,
    input  wire logic [gb5_pkg::LINE_WORD_W-1:0] wr_data
);
    import gb5_pkg::*;

    logic [LINE_WORD_W-1:0] line_mem [DEPTH];
    logic [LINE_WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ sv/gb5_window.sv @@
// 5x5 sliding window and registered weighted row sums.
`default_nettype none
module gb5_window (
    input  wire logic                aclk,
    input  wire logic                shift_en,
    input  wire gb5_pkg::column_t    col_in,
    input  wire logic                sum_en,
    output gb5_pkg::row_sums_t       row_sums
);
    import gb5_pkg::*;

    logic [PIX_W-1:0] win_reg [TAPS][TAPS];
    row_sums_t        row_sum_reg;
    row_sums_t        row_sum_next;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < TAPS; i++) begin
                for (int j = 0; j < TAPS - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][TAPS-1] <= col_in[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            row_sum_next[i] = '0;
            for (int j = 0; j < TAPS; j++) begin
                row_sum_next[i] = row_sum_next[i]
                    + ROWSUM_W'(win_reg[i][j]) * ROWSUM_W'(KERNEL[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            row_sum_reg <= row_sum_next;
        end
    end

    assign row_sums = row_sum_reg;

endmodule
`default_nettype wire

@@ sv/gb5_divide.sv @@
// Total of row sums and divide by 159 through a reciprocal multiply.
`default_nettype none
module gb5_divide (
    input  wire logic                      aclk,
    input  wire logic                      total_en,
    input  wire gb5_pkg::row_sums_t        row_sums,
    input  wire logic                      out_en,
    output logic      [gb5_pkg::PIX_W-1:0] blurred
);
    import gb5_pkg::*;

    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  total_next;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  blurred_reg;

    always_comb begin
        total_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            total_next = total_next + SUM_W'(row_sums[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (total_en) begin
            total_reg <= total_next;
        end
    end

    assign prod = PROD_W'(total_reg) * PROD_W'(DIV_RECIP);

    always_ff @(posedge aclk) begin
        if (out_en) begin
            blurred_reg <= prod[DIV_SHIFT +: PIX_W];
        end
    end

    assign blurred = blurred_reg;

endmodule
`default_nettype wire

@@ bench/tb_gaussian_blur_5x5_core.sv @@
// Self-checking testbench for the 5x5 Gaussian blur core: random frames checked against a predictor.
`timescale 1ns / 1ps
module tb_gaussian_blur_5x5_core;
    import gb5_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int DIVISOR      = 159;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [PIX_W-1:0]     blurred;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } blur_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [PIX_W-1:0]        pending_pixels [$];
    blur_result_t            blur_expect_q [$];
    blur_result_t            got_res;
    blur_result_t            want_res;
    logic                    pix_taken   = 1'b0;
    int                      src_idle_pct   = 0;
    int                      sink_stall_pct = 0;
    int                      err_count   = 0;
    int                      cycle_count = 0;

    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(WIDTH_RST);
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(HEIGHT_RST);
    logic [PIX_W-1:0]        line_mem [LINES][MAX_WIDTH_DEF];
    logic [PIX_W-1:0]        win [TAPS][TAPS];
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    gaussian_blur_5x5_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40) begin
            $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                     cycle_count, what, got, want);
        end
        err_count++;
    endtask

    task automatic blur_apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_reg = data[WIDTH_REG_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = data[HEIGHT_REG_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            default: ;
        endcase
    endtask

    task automatic blur_take_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      w, h, c, r, sum;
        int               i, j;
        logic [PIX_W-1:0] tap_col [TAPS];
        blur_result_t     res;
        w = (width_reg < MIN_DIM) ? MIN_DIM :
            (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        h = (height_reg < MIN_DIM) ? MIN_DIM :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;

        for (i = 0; i < LINES; i++) tap_col[i] = line_mem[i][c];
        tap_col[LINES] = pix;
        for (i = 0; i < LINES - 1; i++) line_mem[i][c] = line_mem[i + 1][c];
        line_mem[LINES-1][c] = pix;

        for (i = 0; i < TAPS; i++) begin
            for (j = 0; j < TAPS - 1; j++) win[i][j] = win[i][j + 1];
            win[i][TAPS-1] = tap_col[i];
        end

        if (r >= 4 && c >= 4) begin
            sum = 0;
            for (i = 0; i < TAPS; i++) begin
                for (j = 0; j < TAPS; j++) sum += 32'(win[i][j]) * 32'(KERNEL[i][j]);
            end
            res.blurred = PIX_W'(sum / DIVISOR);
            res.row     = ROW_W'(r - 2);
            res.col     = OUT_COL_W'(c - 2);
            res.last    = (r == h - 1) && (c == w - 1);
            blur_expect_q.push_back(res);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // input side: sample acceptance, then feed the predictor
    always @(posedge aclk) begin
        pix_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            blur_take_pixel(s_tdata);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || pix_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pixels.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res.blurred = m_tdata[7:0];
            got_res.row     = m_tdata[19:8];
            got_res.col     = m_tdata[29:20];
            got_res.last    = m_tlast;
            if (blur_expect_q.size() == 0) begin
                report_mismatch("unexpected transaction, blurred", got_res.blurred, -1);
            end else begin
                want_res = blur_expect_q.pop_front();
                if (got_res.blurred !== want_res.blurred)
                    report_mismatch("blurred", got_res.blurred, want_res.blurred);
                if (got_res.row !== want_res.row)
                    report_mismatch("out_row", got_res.row, want_res.row);
                if (got_res.col !== want_res.col)
                    report_mismatch("out_col", got_res.col, want_res.col);
                if (got_res.last !== want_res.last)
                    report_mismatch("last_of_frame", got_res.last, want_res.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 62; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 62; end
            default:   begin src_idle_pct = 32; sink_stall_pct = 32; end
        endcase
    endtask

    // wait until the core holds no transaction, then let the pipeline empty
    task automatic settle();
        while (pending_pixels.size() != 0 || s_tvalid || blur_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        blur_apply_cfg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_pixels(input int count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(15);
            if (pick == 0)
                pending_pixels.push_back('0);
            else if (pick == 1)
                pending_pixels.push_back('1);
            else
                pending_pixels.push_back(PIX_W'($urandom_range(255)));
        end
    endtask

    task automatic run_frames(input logic [CFG_DATA_W-1:0] w_data,
                              input logic [CFG_DATA_W-1:0] h_data,
                              input int count, input idle_mode_t mode);
        settle();
        write_cfg(REG_IMAGE_WIDTH, w_data);
        write_cfg(REG_IMAGE_HEIGHT, h_data);
        set_idle(mode);
        add_pixels(count);
    endtask

    initial begin
        int k, n;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full-scale flat frame at the smallest size
        settle();
        set_idle(IDLE_NONE);
        write_cfg(REG_IMAGE_WIDTH, 13'd5);
        write_cfg(REG_IMAGE_HEIGHT, 13'd5);
        repeat (25) pending_pixels.push_back('1);

        run_frames(13'd0, 13'd0, 60, IDLE_SRC);
        run_frames(13'h0806, 13'd6, 90, IDLE_SINK);
        run_frames(13'd7, 13'h1FFF, 70, IDLE_BOTH);
        run_frames(13'd100, 13'd5, 520, IDLE_BOTH);
        run_frames(13'd2047, 13'd4096, 60, IDLE_NONE);
        run_frames(13'd5, 13'd4096, 60, IDLE_SRC);

        for (k = 0; k < 5; k++) begin
            n = $urandom_range(60, 140);
            run_frames(CFG_DATA_W'($urandom_range(5, 14)), CFG_DATA_W'($urandom_range(5, 10)),
                       n / 2, idle_mode_t'(k % 4));
            // unknown index: frame position must carry on
            settle();
            write_cfg((k % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_W'($urandom_range(8191)));
            add_pixels(n - n / 2);
        end

        settle();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
